[design/fbe_pkg.sv]
// Shared types, constants and the modular helper for the fast base extension block.
`default_nettype none
package fbe_pkg;
  localparam int WORD_W     = 60;
  localparam int TBL_DEPTH  = 32;
  localparam int TBL_AW     = 5;
  localparam int RES_FIELDS = 4;
  localparam int RED_STAGES = WORD_W;
  localparam int MUL_STAGES = 3 * WORD_W;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_CONVERT = 1'b1
  } action_t;

  // Conditional subtract: s is known to lie below 2*m.
  function automatic word_t cond_sub(logic [WORD_W:0] s, word_t m);
    logic [WORD_W:0] d;
    d = s - {1'b0, m};
    return (s >= {1'b0, m}) ? d[WORD_W-1:0] : s[WORD_W-1:0];
  endfunction
endpackage
`default_nettype wire

[design/fbe_cmd_if.sv]
// Command channel interface: table loads and coefficient conversions.
`default_nettype none
interface fbe_cmd_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [fbe_pkg::TBL_AW-1:0] table_index;
  logic [fbe_pkg::WORD_W-1:0] table_value;
  logic [fbe_pkg::WORD_W-1:0] residue_0;
  logic [fbe_pkg::WORD_W-1:0] residue_1;
  logic [fbe_pkg::WORD_W-1:0] residue_2;
  logic [fbe_pkg::WORD_W-1:0] residue_3;

  modport source (output valid, action, table_index, table_value,
                  residue_0, residue_1, residue_2, residue_3, input ready);
  modport sink   (input valid, action, table_index, table_value,
                  residue_0, residue_1, residue_2, residue_3, output ready);
endinterface
`default_nettype wire

[design/fbe_res_if.sv]
// Result channel interface: extended residues modulo the P moduli.
`default_nettype none
interface fbe_res_if;
  logic                       valid;
  logic                       ready;
  logic [fbe_pkg::WORD_W-1:0] ext_residue_0;
  logic [fbe_pkg::WORD_W-1:0] ext_residue_1;

  modport source (output valid, ext_residue_0, ext_residue_1, input ready);
  modport sink   (input valid, ext_residue_0, ext_residue_1, output ready);
endinterface
`default_nettype wire

[design/fbe_modmul.sv]
// Fully pipelined bit-serial modular multiplier with sideband data.
`default_nettype none
module fbe_modmul #(
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  fbe_pkg::word_t        a,
  input  fbe_pkg::word_t        b,
  input  fbe_pkg::word_t        m,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_valid,
  output fbe_pkg::word_t        res,
  output fbe_pkg::word_t        m_out,
  output logic [SIDE_W-1:0]     side_out
);
  import fbe_pkg::*;

  localparam int NS = MUL_STAGES;

  logic              vld  [NS];
  word_t             ar_q [NS];
  word_t             r_q  [NS];
  word_t             a_q  [NS];
  word_t             b_q  [NS];
  word_t             m_q  [NS];
  logic [SIDE_W-1:0] s_q  [NS];

  // The first WORD_W stages reduce a modulo m one bit at a time; then each bit
  // of b takes a doubling stage and a conditional add stage.
  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic              v_i;
    word_t             ar_i, r_i, a_i, b_i, m_i, ar_n, r_n;
    logic [SIDE_W-1:0] s_i;

    if (s == 0) begin : g_head
      assign v_i  = in_valid;
      assign ar_i = '0;
      assign r_i  = '0;
      assign a_i  = a;
      assign b_i  = b;
      assign m_i  = m;
      assign s_i  = side_in;
    end else begin : g_body
      assign v_i  = vld[s-1];
      assign ar_i = ar_q[s-1];
      assign r_i  = r_q[s-1];
      assign a_i  = a_q[s-1];
      assign b_i  = b_q[s-1];
      assign m_i  = m_q[s-1];
      assign s_i  = s_q[s-1];
    end

    if (s < RED_STAGES) begin : g_red
      assign ar_n = cond_sub({ar_i, a_i[WORD_W-1-s]}, m_i);
      assign r_n  = r_i;
    end else if (((s - RED_STAGES) % 2) == 0) begin : g_dbl
      assign ar_n = ar_i;
      assign r_n  = cond_sub({r_i, 1'b0}, m_i);
    end else begin : g_add
      localparam int BIT = WORD_W - 1 - (s - RED_STAGES) / 2;
      assign ar_n = ar_i;
      assign r_n  = b_i[BIT] ? cond_sub({1'b0, r_i} + {1'b0, ar_i}, m_i) : r_i;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ar_q[s] <= ar_n;
        r_q[s]  <= r_n;
        a_q[s]  <= a_i;
        b_q[s]  <= b_i;
        m_q[s]  <= m_i;
        s_q[s]  <= s_i;
      end
    end
  end

  // A zero modulus gives zero.
  assign out_valid = vld[NS-1];
  assign res       = (m_q[NS-1] == '0) ? '0 : r_q[NS-1];
  assign m_out     = m_q[NS-1];
  assign side_out  = s_q[NS-1];
endmodule
`default_nettype wire

[design/fbe_lane.sv]
// One Q lane: scales its residue by the inverse, then multiplies into every P modulus.
`default_nettype none
module fbe_lane #(
  parameter int NUM_P = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  fbe_pkg::word_t x,
  input  fbe_pkg::word_t q,
  input  fbe_pkg::word_t inv,
  input  fbe_pkg::word_t hat  [NUM_P],
  input  fbe_pkg::word_t p    [NUM_P],
  output logic           out_valid,
  output fbe_pkg::word_t term [NUM_P],
  output fbe_pkg::word_t pmod [NUM_P],
  output logic           pzero[NUM_P]
);
  import fbe_pkg::*;

  localparam int SW = 2 * NUM_P * WORD_W;

  logic [SW-1:0] side_in, side_out;
  logic          v_valid;
  word_t         v;
  word_t         hat_d [NUM_P];
  word_t         p_d   [NUM_P];

  always_comb begin
    for (int j = 0; j < NUM_P; j++) begin
      side_in[j*WORD_W +: WORD_W]           = hat[j];
      side_in[(NUM_P+j)*WORD_W +: WORD_W]   = p[j];
    end
  end

  fbe_modmul #(.SIDE_W(SW)) u_scale (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .a(x), .b(inv), .m(q), .side_in(side_in),
    .out_valid(v_valid), .res(v), .m_out(), .side_out(side_out)
  );

  for (genvar j = 0; j < NUM_P; j++) begin : g_p
    logic zero_in;
    assign hat_d[j] = side_out[j*WORD_W +: WORD_W];
    assign p_d[j]   = side_out[(NUM_P+j)*WORD_W +: WORD_W];
    assign zero_in  = (p_d[j] == '0);

    if (j == 0) begin : g_first
      fbe_modmul #(.SIDE_W(1)) u_term (
        .clk(clk), .rst(rst), .en(en), .in_valid(v_valid),
        .a(hat_d[j]), .b(v), .m(p_d[j]), .side_in(zero_in),
        .out_valid(out_valid), .res(term[j]), .m_out(pmod[j]), .side_out(pzero[j])
      );
    end else begin : g_rest
      fbe_modmul #(.SIDE_W(1)) u_term (
        .clk(clk), .rst(rst), .en(en), .in_valid(v_valid),
        .a(hat_d[j]), .b(v), .m(p_d[j]), .side_in(zero_in),
        .out_valid(), .res(term[j]), .m_out(pmod[j]), .side_out(pzero[j])
      );
    end
  end
endmodule
`default_nettype wire

[design/fbe_merge.sv]
// Merging stage: modular accumulation of the lane terms, one lane per stage.
`default_nettype none
module fbe_merge #(
  parameter int NUM_Q = 4,
  parameter int NUM_P = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  fbe_pkg::word_t term  [NUM_Q][NUM_P],
  input  fbe_pkg::word_t pmod  [NUM_P],
  input  logic           pzero [NUM_P],
  output logic           out_valid,
  output fbe_pkg::word_t acc   [NUM_P]
);
  import fbe_pkg::*;

  logic  vld   [NUM_Q];
  word_t acc_q [NUM_Q][NUM_P];
  word_t t_q   [NUM_Q][NUM_Q][NUM_P];
  word_t p_q   [NUM_Q][NUM_P];
  logic  z_q   [NUM_Q][NUM_P];

  for (genvar s = 0; s < NUM_Q; s++) begin : g_stage
    logic  v_i;
    word_t t_i   [NUM_Q][NUM_P];
    word_t p_i   [NUM_P];
    logic  z_i   [NUM_P];
    word_t acc_n [NUM_P];

    if (s == 0) begin : g_head
      assign v_i = in_valid;
      assign t_i = term;
      assign p_i = pmod;
      assign z_i = pzero;
      assign acc_n = term[0];
    end else begin : g_body
      assign v_i = vld[s-1];
      assign t_i = t_q[s-1];
      assign p_i = p_q[s-1];
      assign z_i = z_q[s-1];
      for (genvar j = 0; j < NUM_P; j++) begin : g_add
        assign acc_n[j] = cond_sub({1'b0, acc_q[s-1][j]} + {1'b0, t_i[s][j]}, p_i[j]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_q[s] <= acc_n;
        t_q[s]   <= t_i;
        p_q[s]   <= p_i;
        z_q[s]   <= z_i;
      end
    end
  end

  assign out_valid = vld[NUM_Q-1];
  for (genvar j = 0; j < NUM_P; j++) begin : g_out
    assign acc[j] = z_q[NUM_Q-1][j] ? '0 : acc_q[NUM_Q-1][j];
  end
endmodule
`default_nettype wire

[design/rns_fast_base_extension.sv]
// Top level of the fast RNS base extension block from basis Q to moduli P.
//
//  channel | dir | words carried
//  cmd     | in  | action, table_index, table_value, residue_0..residue_3
//  res     | out | ext_residue_0, ext_residue_1 (one word per convert word)
//
//  Throughput is one word per cycle while the output buffer has room: every
//  lane multiplier is a fully pipelined bit-serial unit with one modular add
//  or compare per stage. A convert word passes through the two chained
//  multipliers in each lane, the merge stages and then the output buffer.
//  Reset clears the pipeline valid bits and the output buffer; the constant
//  table holds no reset value and must be loaded before use.
//  The pipeline stalls only when the two-word output buffer is full.
`default_nettype none
module rns_fast_base_extension #(
  parameter int NUM_Q    = 4,
  parameter int NUM_P    = 2,
  parameter int MOD_BITS = 60
) (
  input  logic      clk,
  input  logic      rst,
  fbe_cmd_if.sink   cmd,
  fbe_res_if.source res
);
  import fbe_pkg::*;

  // Table words are kept at the modulus width, capped at the field width.
  localparam int TW = (MOD_BITS < WORD_W) ? MOD_BITS : WORD_W;

  logic [TW-1:0] tbl [TBL_DEPTH];
  word_t         tw  [TBL_DEPTH];

  logic [1:0] count;
  logic       wr_ptr, rd_ptr;
  logic       en, accept, convert, push, pop;

  // The pipeline advances whenever the output buffer has room; a word still
  // waiting at the output does not stop new words from entering.
  assign en        = (count != 2'd2);
  assign cmd.ready = en;
  assign accept    = cmd.valid && en;
  assign convert   = accept && (action_t'(cmd.action) == ACT_CONVERT);

  // Constant table. A load word writes one entry; a convert word samples all
  // entries it needs on entry, so later loads never disturb words in flight.
  always_ff @(posedge clk) begin
    if (accept && (action_t'(cmd.action) == ACT_LOAD)) begin
      tbl[cmd.table_index] <= cmd.table_value[TW-1:0];
    end
  end

  for (genvar k = 0; k < TBL_DEPTH; k++) begin : g_tw
    assign tw[k] = WORD_W'(tbl[k]);
  end

  word_t rin [RES_FIELDS];
  assign rin[0] = cmd.residue_0;
  assign rin[1] = cmd.residue_1;
  assign rin[2] = cmd.residue_2;
  assign rin[3] = cmd.residue_3;

  word_t x_in  [NUM_Q];
  word_t q_in  [NUM_Q];
  word_t inv_in[NUM_Q];
  word_t hat_in[NUM_Q][NUM_P];
  word_t p_in  [NUM_P];

  // Layout addresses beyond the table name no storage and read as zero.
  for (genvar j = 0; j < NUM_P; j++) begin : g_p_rd
    localparam int AP = NUM_Q + j;
    if (AP < TBL_DEPTH) begin : g_in
      assign p_in[j] = tw[AP];
    end else begin : g_out
      assign p_in[j] = '0;
    end
  end

  for (genvar i = 0; i < NUM_Q; i++) begin : g_q_rd
    localparam int AQ = i;
    localparam int AI = NUM_Q + NUM_P + i;
    if (i < RES_FIELDS) begin : g_x
      assign x_in[i] = rin[i];
    end else begin : g_x0
      assign x_in[i] = '0;
    end
    if (AQ < TBL_DEPTH) begin : g_q
      assign q_in[i] = tw[AQ];
    end else begin : g_q0
      assign q_in[i] = '0;
    end
    if (AI < TBL_DEPTH) begin : g_i
      assign inv_in[i] = tw[AI];
    end else begin : g_i0
      assign inv_in[i] = '0;
    end
    for (genvar j = 0; j < NUM_P; j++) begin : g_h
      localparam int AH = 2 * NUM_Q + NUM_P + i * NUM_P + j;
      if (AH < TBL_DEPTH) begin : g_in
        assign hat_in[i][j] = tw[AH];
      end else begin : g_out
        assign hat_in[i][j] = '0;
      end
    end
  end

  // One lane per Q modulus; all lanes share the same latency, so lane zero
  // supplies the valid bit, the P moduli and their zero flags to the merge.
  logic  lane_valid;
  word_t lane_term [NUM_Q][NUM_P];
  word_t lane_pmod [NUM_P];
  logic  lane_pzero[NUM_P];

  for (genvar i = 0; i < NUM_Q; i++) begin : g_lane
    if (i == 0) begin : g_first
      fbe_lane #(.NUM_P(NUM_P)) u_lane (
        .clk(clk), .rst(rst), .en(en), .in_valid(convert),
        .x(x_in[i]), .q(q_in[i]), .inv(inv_in[i]), .hat(hat_in[i]), .p(p_in),
        .out_valid(lane_valid), .term(lane_term[i]), .pmod(lane_pmod),
        .pzero(lane_pzero)
      );
    end else begin : g_rest
      fbe_lane #(.NUM_P(NUM_P)) u_lane (
        .clk(clk), .rst(rst), .en(en), .in_valid(convert),
        .x(x_in[i]), .q(q_in[i]), .inv(inv_in[i]), .hat(hat_in[i]), .p(p_in),
        .out_valid(), .term(lane_term[i]), .pmod(), .pzero()
      );
    end
  end

  logic  mrg_valid;
  word_t mrg_acc [NUM_P];

  fbe_merge #(.NUM_Q(NUM_Q), .NUM_P(NUM_P)) u_merge (
    .clk(clk), .rst(rst), .en(en), .in_valid(lane_valid),
    .term(lane_term), .pmod(lane_pmod), .pzero(lane_pzero),
    .out_valid(mrg_valid), .acc(mrg_acc)
  );

  // Two-word output buffer between the pipeline and the result channel.
  word_t ext1;
  if (NUM_P >= 2) begin : g_e1
    assign ext1 = mrg_acc[1];
  end else begin : g_e1z
    assign ext1 = '0;
  end

  logic [2*WORD_W-1:0] obuf [2];

  assign push = en && mrg_valid;
  assign pop  = res.valid && res.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wr_ptr] <= {ext1, mrg_acc[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign res.valid         = (count != 2'd0);
  assign res.ext_residue_0 = obuf[rd_ptr][WORD_W-1:0];
  assign res.ext_residue_1 = obuf[rd_ptr][2*WORD_W-1:WORD_W];

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("output buffer count exceeds its depth");
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> !cmd.ready)
    else $error("command accepted while output buffer stays full");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> !push)
    else $error("result pushed into a full output buffer");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("buffer pointers disagree with count");
`endif
endmodule
`default_nettype wire

[dv/rns_fast_base_extension_tb.sv]
// Self-checking testbench for the fast RNS base extension block.
`default_nettype none
module rns_fast_base_extension_tb;
  import fbe_pkg::*;

  // Layout of the constant table for NUM_Q = 4 and NUM_P = 2.
  localparam int NQ       = 4;
  localparam int NP       = 2;
  localparam int A_Q      = 0;
  localparam int A_P      = NQ;
  localparam int A_INV    = NQ + NP;
  localparam int A_HAT    = 2 * NQ + NP;
  localparam int USED     = A_HAT + NQ * NP;
  localparam int LATENCY  = 2 * 3 * 60 + NQ + 1;
  localparam int N_RANDOM = 1330;
  localparam word_t ALL_ONES = {WORD_W{1'b1}};

  typedef struct packed {
    word_t ext0;
    word_t ext1;
  } ext_pair_t;

  // The scoreboard keeps its own copy of the table. It turns every accepted
  // convert word into the pair of extended residues that should come back.
  class ext_scoreboard;
    word_t     tbl [TBL_DEPTH];
    ext_pair_t pending_ext [$];
    int        n_mismatch;
    int        n_matched;
    int        n_loads;
    int        n_converts;

    function new();
      foreach (tbl[k]) tbl[k] = '0;
      n_mismatch = 0;
      n_matched  = 0;
      n_loads    = 0;
      n_converts = 0;
    endfunction

    // A modulus of zero yields zero; operands are reduced first.
    function word_t mod_mul(word_t a, word_t b, word_t m);
      logic [2*WORD_W-1:0] prod;
      if (m == '0) return '0;
      prod = {{WORD_W{1'b0}}, a % m} * {{WORD_W{1'b0}}, b % m};
      return word_t'(prod % {{WORD_W{1'b0}}, m});
    endfunction

    function word_t mod_add(word_t a, word_t b, word_t m);
      logic [WORD_W:0] s;
      if (m == '0) return '0;
      s = {1'b0, a % m} + {1'b0, b % m};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[WORD_W-1:0];
    endfunction

    function void note_word(action_t act, logic [TBL_AW-1:0] idx, word_t val,
                            word_t x0, word_t x1, word_t x2, word_t x3);
      word_t     x [NQ];
      word_t     v [NQ];
      word_t     acc;
      ext_pair_t e;
      if (act == ACT_LOAD) begin
        tbl[idx] = val;
        n_loads++;
        return;
      end
      x[0] = x0; x[1] = x1; x[2] = x2; x[3] = x3;
      for (int i = 0; i < NQ; i++) begin
        v[i] = mod_mul(x[i], tbl[A_INV+i], tbl[A_Q+i]);
      end
      e = '0;
      for (int j = 0; j < NP; j++) begin
        acc = '0;
        for (int i = 0; i < NQ; i++) begin
          acc = mod_add(acc, mod_mul(v[i], tbl[A_HAT+i*NP+j], tbl[A_P+j]), tbl[A_P+j]);
        end
        if (j == 0) e.ext0 = acc;
        else e.ext1 = acc;
      end
      pending_ext = {pending_ext, e};
      n_converts++;
    endfunction

    function void check_result(word_t got0, word_t got1);
      ext_pair_t e;
      if (pending_ext.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("ERROR: unexpected result word %h %h", got0, got1);
        return;
      end
      e = pending_ext.pop_front();
      if (e.ext0 !== got0 || e.ext1 !== got1) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("ERROR: ext_residue mismatch: expected %h %h, got %h %h",
                   e.ext0, e.ext1, got0, got1);
      end else begin
        n_matched++;
      end
    endfunction

    function int outstanding();
      return pending_ext.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  fbe_cmd_if cmd();
  fbe_res_if res();
  ext_scoreboard sb;

  rns_fast_base_extension dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd.sink),
    .res(res.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Both channels are observed at the rising edge only.
  always @(posedge clk) begin
    if (!rst && cmd.valid && cmd.ready)
      sb.note_word(action_t'(cmd.action), cmd.table_index, cmd.table_value,
                   cmd.residue_0, cmd.residue_1, cmd.residue_2, cmd.residue_3);
    if (!rst && res.valid && res.ready)
      sb.check_result(res.ext_residue_0, res.ext_residue_1);
  end

  // The receiver holds ready low for a random stall, possibly none, before each
  // word, then waits with ready high until a word is taken.
  initial begin
    int stall;
    res.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, 3);
      if (stall != 0) begin
        res.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res.ready = 1'b1;
      do @(posedge clk); while (!res.valid);
      @(negedge clk);
    end
  end

  function automatic word_t rand_word();
    return word_t'({$urandom, $urandom});
  endfunction

  // Moduli cover the full width, short widths, one, zero and the maximum.
  function automatic word_t rand_modulus();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return word_t'(1);
      2: return ALL_ONES;
      3, 4: return rand_word() >> $urandom_range(1, 58);
      default: return rand_word() | (word_t'(1) << (WORD_W - 1));
    endcase
  endfunction

  // Residues are mostly reduced, with raw patterns and the extremes mixed in.
  function automatic word_t rand_residue(word_t m);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ALL_ONES;
      2, 3: return rand_word();
      default: return (m == '0) ? rand_word() : rand_word() % m;
    endcase
  endfunction

  // Sends one word: a random gap with valid low, then valid high until taken.
  task automatic send_word(action_t act, logic [TBL_AW-1:0] idx, word_t val,
                           word_t x0, word_t x1, word_t x2, word_t x3);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      cmd.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.valid       = 1'b1;
    cmd.action      = act;
    cmd.table_index = idx;
    cmd.table_value = val;
    cmd.residue_0   = x0;
    cmd.residue_1   = x1;
    cmd.residue_2   = x2;
    cmd.residue_3   = x3;
    do @(posedge clk); while (!cmd.ready);
    @(negedge clk);
  endtask

  task automatic load_word(int idx, word_t val);
    send_word(ACT_LOAD, idx[TBL_AW-1:0], val, rand_word(), rand_word(), rand_word(),
              rand_word());
  endtask

  task automatic convert_word(word_t x0, word_t x1, word_t x2, word_t x3);
    send_word(ACT_CONVERT, TBL_AW'(rand_word() >> (WORD_W - TBL_AW)), rand_word(),
              x0, x1, x2, x3);
  endtask

  // The sender holds off until every convert word in flight has returned,
  // so the pipeline runs fully empty before the next burst.
  task automatic drain_results();
    cmd.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int idx;
    sb = new();
    rst             = 1'b1;
    cmd.valid       = 1'b0;
    cmd.action      = ACT_LOAD;
    cmd.table_index = '0;
    cmd.table_value = '0;
    cmd.residue_0   = '0;
    cmd.residue_1   = '0;
    cmd.residue_2   = '0;
    cmd.residue_3   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. Every used entry is loaded before the first convert.
    // q_0 is the largest modulus, q_3 is a zero modulus and p_1 is one, so
    // the zero modulus and the trivial modulus both show up at once.
    load_word(A_Q + 0, ALL_ONES);
    load_word(A_Q + 1, rand_word() | (word_t'(1) << (WORD_W - 1)));
    load_word(A_Q + 2, word_t'(3));
    load_word(A_Q + 3, '0);
    load_word(A_P + 0, ALL_ONES - word_t'(2));
    load_word(A_P + 1, word_t'(1));
    for (int k = A_INV; k < USED; k++) load_word(k, rand_word());
    convert_word('0, '0, '0, '0);
    convert_word(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    convert_word(ALL_ONES - word_t'(1), word_t'(2), word_t'(1), rand_word());
    drain_results();
    // A second table with unreduced hat words against a short modulus.
    load_word(A_P + 1, word_t'(97));
    load_word(A_Q + 3, word_t'(5));
    convert_word(rand_word(), rand_word(), rand_word(), rand_word());
    convert_word(word_t'(1), word_t'(1), word_t'(1), word_t'(1));

    // Random part: mostly streams of convert words, with short reload bursts
    // that rewrite used entries and touch the unused tail of the table.
    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 11) == 0) begin
        drain_results();
        repeat ($urandom_range(1, 4)) begin
          idx = $urandom_range(0, TBL_DEPTH - 1);
          if (idx < A_INV) load_word(idx, rand_modulus());
          else load_word(idx, rand_word());
          n++;
        end
      end else begin
        convert_word(rand_residue(sb.tbl[A_Q+0]), rand_residue(sb.tbl[A_Q+1]),
                     rand_residue(sb.tbl[A_Q+2]), rand_residue(sb.tbl[A_Q+3]));
      end
    end
    cmd.valid = 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("Covered %0d table loads and %0d conversions, %0d results matched.",
             sb.n_loads, sb.n_converts, sb.n_matched);
    $display("Tables included zero, unit, short and full-width moduli; mismatches: %0d.",
             sb.n_mismatch);
    if (sb.n_mismatch == 0 && sb.outstanding() == 0) begin
      $display("rns_fast_base_extension regression: pass");
    end else begin
      $display("rns_fast_base_extension regression: fail");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #8000000;
    $display("ERROR: timeout");
    $display("rns_fast_base_extension regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
